// ----- src/hds_pkg.sv -----
// Package for the heat diffusion stencil step: widths, types and cell controls.
// No dependencies; every other file of the block imports it.
package hds_pkg;

  localparam int SAMPLE_BITS = 20;
  localparam int GAIN_BITS   = 16;
  localparam int GUARD_BITS  = 8;
  localparam int WIN         = 9;
  localparam int CENTRE      = 4;

  localparam int VAL_BITS  = SAMPLE_BITS + GUARD_BITS;
  localparam int LAP_BITS  = VAL_BITS + 2;
  localparam int PROD_BITS = LAP_BITS + GAIN_BITS + 1;
  localparam int K_BITS    = PROD_BITS - GAIN_BITS;
  localparam int ACC_BITS  = K_BITS + 3;
  localparam int Y_BITS    = ACC_BITS - GUARD_BITS - 1;

  localparam int DIV_SHIFT     = Y_BITS + 2;
  localparam int DIV_MUL_BITS  = DIV_SHIFT - 1;
  localparam int DIV_PROD_BITS = Y_BITS + 1 + DIV_MUL_BITS;
  localparam logic [63:0] DIV_MUL_W = ((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3;
  localparam logic [DIV_MUL_BITS-1:0] DIV_MUL = DIV_MUL_W[DIV_MUL_BITS-1:0];
  localparam logic [63:0] DIV_OFF_W = 64'd3 << (Y_BITS - 1);
  localparam logic [Y_BITS:0] DIV_OFF = DIV_OFF_W[Y_BITS:0];

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = GAIN_BITS;
  localparam logic [CFG_IDX_BITS-1:0] REG_METHOD = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN   = 1'd1;
  localparam logic METHOD_EULER = 1'b0;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd16384;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [VAL_BITS-1:0]    val_t;
  typedef logic signed [LAP_BITS-1:0]    lap_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [K_BITS-1:0]      k_t;
  typedef logic signed [K_BITS:0]        ksum_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic signed [ACC_BITS:0]      total_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_LOAD,
    OP_MUL,
    OP_UPD
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    logic [1:0]           stage;
    logic                 keep;
    logic [GAIN_BITS-1:0] gain;
  } cell_ctrl_t;

  function automatic val_t sat_val(ksum_t x);
    val_t hi, lo;
    hi = {1'b0, {(SAMPLE_BITS-1){1'b1}}, {GUARD_BITS{1'b0}}};
    lo = {1'b1, {(VAL_BITS-1){1'b0}}};
    if (x > ksum_t'(hi)) return hi;
    if (x < ksum_t'(lo)) return lo;
    return x[VAL_BITS-1:0];
  endfunction

  function automatic sample_t sat_sample(total_t x);
    sample_t hi, lo;
    hi = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    lo = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    if (x > total_t'(hi)) return hi;
    if (x < total_t'(lo)) return lo;
    return x[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ----- src/hds_if.sv -----
// Stream interfaces of the heat diffusion stencil step: sample beats in, results out.
// Depends on hds_pkg.
interface hds_in_if import hds_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    row_start;
  logic    row_end;
  modport source (output valid, sample, row_start, row_end, input ready);
  modport sink (input valid, sample, row_start, row_end, output ready);
endinterface

interface hds_out_if import hds_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t next_sample;
  logic    is_last;
  modport source (output valid, next_sample, is_last, input ready);
  modport sink (input valid, next_sample, is_last, output ready);
endinterface

// ----- src/heat_diffusion_stencil_step.sv -----
// Top level of the heat diffusion stencil step: nine-cell window, sequencer, output register.
// Depends on hds_pkg, hds_if and hds_cell.
// A row of nine cells holds the newest samples; every result is computed in place by
// the cells, each with its own gain multiplier. A beat that completes a result passes
// through accept, check, load, multiply, update, divide and output in Euler mode, and
// through four multiply/update passes in RK4 mode; a beat that completes no result
// returns from check to idle. The row-end beat drains up to five results; the shift to
// each one after the first is folded into the output state, and a short row shifts
// bubbles in the check state before its first result. A stalled output holds the
// sequencer in its output state.
module heat_diffusion_stencil_step import hds_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  hds_in_if.sink                   in_i,
  hds_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_LOAD, ST_MUL, ST_UPD, ST_DIV, ST_OUT
  } state_e;

  state_e               state_q, state_d;
  logic [1:0]           stage_q, stage_d;
  logic                 flush_q, flush_d;
  logic                 method_q;
  logic [GAIN_BITS-1:0] gain_q;
  logic [DIV_PROD_BITS-1:0] div_q, div_d;
  logic                 out_valid_q, out_last_q;
  sample_t              out_sample_q;

  cell_ctrl_t ctrl;
  logic       head_valid, accept, out_wr, out_last_d;
  sample_t    samples [WIN];
  val_t       vals [WIN];
  acc_t       accs [WIN];
  logic [WIN-1:0] valid;

  for (genvar j = 0; j < WIN; j++) begin : g_cell
    sample_t sh_s;
    logic    sh_v, lv, rv;
    val_t    lval, rval;
    if (j == WIN - 1) begin : g_head
      assign sh_s = in_i.sample;
      assign sh_v = head_valid;
      assign rv   = 1'b0;
      assign rval = '0;
    end else begin : g_body
      assign sh_s = samples[j+1];
      assign sh_v = valid[j+1] & ctrl.keep;
      assign rv   = valid[j+1];
      assign rval = vals[j+1];
    end
    if (j == 0) begin : g_tail
      assign lv   = 1'b0;
      assign lval = '0;
    end else begin : g_inner
      assign lv   = valid[j-1];
      assign lval = vals[j-1];
    end
    hds_cell u_cell (
      .clk_i, .rst_ni, .ctrl_i(ctrl),
      .shift_sample_i(sh_s), .shift_valid_i(sh_v),
      .left_valid_i(lv), .right_valid_i(rv),
      .left_v_i(lval), .right_v_i(rval),
      .sample_o(samples[j]), .valid_o(valid[j]), .v_o(vals[j]), .acc_o(accs[j])
    );
  end

  // result arithmetic on the centre cell
  acc_t                  acc_c, eu_delta, y_full, delta;
  logic signed [Y_BITS-1:0] y;
  logic [Y_BITS:0]       y_off;
  logic [Y_BITS-1:0]     q;
  logic signed [Y_BITS:0] rk_delta;
  total_t                total;
  sample_t               result;

  assign acc_c    = accs[CENTRE];
  assign eu_delta = (acc_c + (acc_t'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
  assign y_full   = (acc_c + (acc_t'(3) <<< GUARD_BITS)) >>> (GUARD_BITS + 1);
  assign y        = y_full[Y_BITS-1:0];
  assign y_off    = $unsigned({y[Y_BITS-1], y}) + DIV_OFF;
  assign div_d    = DIV_PROD_BITS'(y_off) * DIV_PROD_BITS'(DIV_MUL);
  assign q        = div_q[DIV_PROD_BITS-1:DIV_SHIFT];
  assign rk_delta = $signed({1'b0, q}) - $signed({2'b01, {(Y_BITS-1){1'b0}}});
  assign delta    = (method_q == METHOD_EULER) ? eu_delta : acc_t'(rk_delta);
  assign total    = total_t'(samples[CENTRE]) + total_t'(delta);
  assign result   = sat_sample(total);

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_wr     = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);
  assign out_last_d = flush_q && !valid[CENTRE+1];

  always_comb begin
    state_d    = state_q;
    stage_d    = stage_q;
    flush_d    = flush_q;
    ctrl.op    = OP_HOLD;
    ctrl.stage = stage_q;
    ctrl.keep  = 1'b1;
    ctrl.gain  = gain_q;
    head_valid = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          ctrl.op    = OP_SHIFT;
          ctrl.keep  = !in_i.row_start;
          head_valid = 1'b1;
          flush_d    = in_i.row_end;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (valid[CENTRE]) begin
          state_d = ST_LOAD;
        end else if (flush_q) begin
          ctrl.op = OP_SHIFT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LOAD: begin
        ctrl.op = OP_LOAD;
        stage_d = 2'd0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        ctrl.op = OP_MUL;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        ctrl.op = OP_UPD;
        if (method_q == METHOD_EULER || stage_q == 2'd3) begin
          state_d = ST_DIV;
        end else begin
          stage_d = stage_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_DIV: state_d = ST_OUT;
      ST_OUT: begin
        if (out_wr) begin
          if (!flush_q) begin
            state_d = ST_IDLE;
          end else begin
            ctrl.op = OP_SHIFT;
            ctrl.keep = !out_last_d;
            state_d = out_last_d ? ST_IDLE : ST_CHECK;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= 2'd0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      flush_q <= flush_d;
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV) begin
      div_q <= div_d;
    end
    if (out_wr) begin
      out_sample_q <= result;
      out_last_q   <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= 1'b0;
      gain_q   <= GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_METHOD: method_q <= cfg_data_i[0];
        REG_GAIN:   gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.next_sample = out_sample_q;
  assign out_o.is_last     = out_last_q;

  a_newest_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid[WIN-1])
    else $error("accepted beat not held in head cell");

  a_euler_one_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && stage_q != 2'd0) |-> method_q)
    else $error("Euler step ran more than one stage");

  a_row_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_wr && out_last_d) |=> (valid == '0))
    else $error("window not cleared after last result of row");

  a_result_needs_centre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> valid[CENTRE])
    else $error("result started without a centre sample");

endmodule

// ----- src/hds_cell.sv -----
// One grid cell: holds a window sample, its stage value, product and k accumulator.
// Depends on hds_pkg.
module hds_cell import hds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  sample_t    shift_sample_i,
  input  logic       shift_valid_i,
  input  logic       left_valid_i,
  input  logic       right_valid_i,
  input  val_t       left_v_i,
  input  val_t       right_v_i,
  output sample_t    sample_o,
  output logic       valid_o,
  output val_t       v_o,
  output acc_t       acc_o
);

  logic    valid_q;
  sample_t sample_q;
  val_t    v_q, v_d, u;
  prod_t   prod_q, prod_d, rnd;
  acc_t    acc_q, acc_d;
  lap_t    lap;
  k_t      k;
  ksum_t   vsum;
  logic    kzero;

  assign u     = valid_q ? $signed({sample_q, {GUARD_BITS{1'b0}}}) : '0;
  assign kzero = !valid_q || !left_valid_i || !right_valid_i;
  assign lap   = lap_t'(left_v_i) - (lap_t'(v_q) <<< 1) + lap_t'(right_v_i);
  assign prod_d = prod_t'($signed({1'b0, ctrl_i.gain})) * prod_t'(lap);
  assign rnd   = prod_q + (prod_t'(1) <<< (GAIN_BITS - 1));
  assign k     = kzero ? '0 : k_t'(rnd >>> GAIN_BITS);
  assign vsum  = ksum_t'(u) + ((ctrl_i.stage == 2'd2) ? ksum_t'(k) : ksum_t'(k >>> 1));
  assign v_d   = sat_val(vsum);
  assign acc_d = acc_q + ((ctrl_i.stage == 2'd0 || ctrl_i.stage == 2'd3) ?
                          acc_t'(k) : (acc_t'(k) <<< 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.op == OP_SHIFT) begin
      valid_q <= shift_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_SHIFT: sample_q <= shift_sample_i;
      OP_LOAD: begin
        v_q   <= u;
        acc_q <= '0;
      end
      OP_MUL: prod_q <= prod_d;
      OP_UPD: begin
        v_q   <= v_d;
        acc_q <= acc_d;
      end
      default: ;
    endcase
  end

  assign sample_o = sample_q;
  assign valid_o  = valid_q;
  assign v_o      = v_q;
  assign acc_o    = acc_q;

endmodule

// ----- sim/tb_heat_diffusion_stencil_step.sv -----
// Testbench for heat_diffusion_stencil_step: directed table then random rows, with idling.
// Depends on hds_pkg, hds_if and the block; a local predictor supplies expected results.
`timescale 1ns / 1ps

module tb_heat_diffusion_stencil_step;
  import hds_pkg::*;

  localparam int    LIMIT = 400000;
  localparam longint SMX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SMN = -SMX - 1;

  typedef struct {
    sample_t s;
    logic    rs;
    logic    re;
    logic    chk;
    sample_t exp_s;
  } row_t;

  typedef struct {
    sample_t s;
    logic    last;
  } res_t;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  hds_in_if  in_ch ();
  hds_out_if out_ch ();

  heat_diffusion_stencil_step u_dut (
    .clk_i, .rst_ni, .in_i(in_ch), .out_o(out_ch), .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  logic            rk4_mode;
  logic [15:0]     gain_val;
  longint          win_q [9];
  int              fill_n;
  res_t            expected_q [$];
  int              err_cnt, res_cnt, cyc;
  bit              calm, in_busy;
  row_t            directed [$];

  initial begin
    in_ch.valid = 0; in_ch.sample = '0; in_ch.row_start = 0; in_ch.row_end = 0;
    out_ch.ready = 0;
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, res_cnt);
    err_cnt++;
  endtask

  function automatic longint clampl(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint fshift(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint lap_gain(longint a, longint b, longint c);
    return fshift(longint'(gain_val) * (a - 2 * b + c) + (64'sd1 <<< 15), 16);
  endfunction

  function automatic void heat_stage(longint v[9], bit kz[9], ref longint k[9]);
    for (int j = 0; j < 9; j++)
      k[j] = kz[j] ? 0 : lap_gain(v[j-1], v[j], v[j+1]);
  endfunction

  function automatic sample_t step_point(longint vals[9], bit ok[9]);
    longint u[9], v[9], k1[9], k2[9], k3[9], k4[9], lo, hi, dl, num, q;
    bit kz[9];
    lo = SMN * 256; hi = SMX * 256;
    for (int j = 0; j < 9; j++) begin
      u[j] = ok[j] ? vals[j] * 256 : 0;
      kz[j] = (j == 0 || j == 8) ? 1 : (!ok[j] || !ok[j-1] || !ok[j+1]);
    end
    heat_stage(u, kz, k1);
    if (!rk4_mode) begin
      dl = fshift(k1[4] + 128, 8);
    end else begin
      for (int j = 0; j < 9; j++) v[j] = clampl(u[j] + fshift(k1[j], 1), lo, hi);
      heat_stage(v, kz, k2);
      for (int j = 0; j < 9; j++) v[j] = clampl(u[j] + fshift(k2[j], 1), lo, hi);
      heat_stage(v, kz, k3);
      for (int j = 0; j < 9; j++) v[j] = clampl(u[j] + k3[j], lo, hi);
      heat_stage(v, kz, k4);
      num = k1[4] + 2 * k2[4] + 2 * k3[4] + k4[4] + 3 * 256;
      q = num / 1536;
      if (num % 1536 != 0 && num < 0) q--;
      dl = q;
    end
    return sample_t'(clampl(vals[4] + dl, SMN, SMX));
  endfunction

  function automatic void push_point(int d, bit last);
    longint vals[9];
    bit ok[9];
    res_t r;
    for (int j = 0; j < 9; j++) begin
      int wi = 4 - d + j;
      ok[j] = wi >= 9 - fill_n && wi < 9 && wi >= 0;
      vals[j] = ok[j] ? win_q[wi] : 0;
    end
    r.s = step_point(vals, ok);
    r.last = last;
    expected_q.push_back(r);
  endfunction

  function automatic int predict_beat(sample_t s, bit rs, bit re);
    int n = 0;
    if (rs) fill_n = 0;
    for (int j = 0; j < 8; j++) win_q[j] = win_q[j+1];
    win_q[8] = s;
    if (fill_n < 9) fill_n++;
    if (re) begin
      for (int d = (fill_n < 5 ? fill_n : 5) - 1; d >= 0; d--) begin
        push_point(d, d == 0); n++;
      end
      fill_n = 0;
      foreach (win_q[j]) win_q[j] = 0;
    end else if (fill_n >= 5) begin
      push_point(4, 0); n = 1;
    end
    return n;
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == REG_METHOD) rk4_mode = val[0]; else gain_val = val;
  endtask

  task automatic drain_wait();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // drives one beat; returns once accepted
  task automatic send_beat(sample_t s, bit rs, bit re);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_ch.valid <= 1; in_ch.sample <= s; in_ch.row_start <= rs; in_ch.row_end <= re;
    do @(posedge clk_i); while (!in_ch.ready);
    void'(predict_beat(s, rs, re));
  endtask

  task automatic send_row(int len, int kind);
    sample_t base;
    base = sample_t'($urandom);
    for (int i = 0; i < len; i++) begin
      sample_t s;
      case (kind)
        0: s = sample_t'($urandom);
        1: s = sample_t'(base + $signed($urandom_range(0, 8191)) - 4096);
        default: s = $urandom_range(0, 1) ? sample_t'(SMX) : sample_t'(SMN);
      endcase
      send_beat(s, i == 0, i == len - 1);
    end
  endtask

  // receiver: random stalls, compare against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat", out_ch.next_sample, 0);
        end else begin
          res_t e;
          e = expected_q.pop_front();
          if (out_ch.next_sample !== e.s) report("next_sample", out_ch.next_sample, e.s);
          if (out_ch.is_last !== e.last) report("is_last", out_ch.is_last, e.last);
        end
        res_cnt++;
      end
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 4) != 0);
    end
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void add_row(sample_t s, bit rs, bit re, bit chk, sample_t e);
    row_t r;
    r.s = s; r.rs = rs; r.re = re; r.chk = chk; r.exp_s = e;
    directed.push_back(r);
  endfunction

  initial begin
    gain_val = GAIN_RESET; rk4_mode = METHOD_EULER;
    foreach (win_q[j]) win_q[j] = 0;
    fill_n = 0;
    // single-sample rows pass through
    add_row(sample_t'(SMX), 1, 1, 1, sample_t'(SMX));
    add_row(sample_t'(SMN), 1, 1, 1, sample_t'(SMN));
    add_row(20'sd0, 1, 1, 1, 20'sd0);
    // short row of three
    add_row(20'sd1000, 1, 0, 0, '0);
    add_row(-20'sd5000, 0, 0, 0, '0);
    add_row(20'sd7, 0, 1, 0, '0);
    // unterminated row then restart
    add_row(20'sd100, 1, 0, 0, '0);
    add_row(20'sd200, 0, 0, 0, '0);
    add_row(20'sd300, 1, 0, 0, '0);
    for (int i = 0; i < 6; i++)
      add_row(i[0] ? sample_t'(SMX) : sample_t'(SMN), 0, i == 5, 0, '0);
    // missing row_start
    for (int i = 0; i < 6; i++)
      add_row(sample_t'(i * 12345 - 30000), 0, i == 5, 0, '0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    // checked rows give one result, the newest entry
    foreach (directed[i]) begin
      send_beat(directed[i].s, directed[i].rs, directed[i].re);
      if (directed[i].chk && expected_q[$].s !== directed[i].exp_s)
        report("table", expected_q[$].s, directed[i].exp_s);
    end
    in_ch.valid <= 0;
    drain_wait();

    for (int ph = 0; ph < 6; ph++) begin
      logic [15:0] g;
      case (ph)
        0: g = 16'd0;
        1: g = 16'd32768;
        2: g = 16'hFFFF;
        default: g = $urandom;
      endcase
      write_reg(REG_METHOD, ph[0] ? 16'hFFFF : 16'hFFFE);
      write_reg(REG_GAIN, g);
      for (int r = 0; r < 6; r++) begin
        int len, kind;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 12);
        kind = $urandom_range(0, 9) < 6 ? 1 : ($urandom_range(0, 2) == 0 ? 2 : 0);
        if (ph == 5 && r >= 3) calm = 1;
        if ($urandom_range(0, 7) == 0) begin
          send_beat(sample_t'($urandom), 1, 0);
          send_beat(sample_t'($urandom), 0, 0);
        end
        send_row(len, kind);
      end
      in_ch.valid <= 0;
      drain_wait();
    end

    wait (expected_q.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("covered Euler and RK4 at zero, half, maximum and random gains; %0d results",
             res_cnt);
    $display("rows: single-sample, short, unterminated, implicit start, saturating");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
